// File: rtl/i2c_eeprom_burst_master_top_defines.svh
// Assertion macros shared by the checker files of this block.
`ifndef I2C_EEPROM_BURST_MASTER_TOP_DEFINES_SVH
`define I2C_EEPROM_BURST_MASTER_TOP_DEFINES_SVH

// Concurrent assertion clocked on the rising edge and switched off during reset.
`define I2CEBM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, for a property whose check is counted from the cycle after the trigger.
`define I2CEBM_ASSERT_NEXT(label, clk, rstn, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) \
        else $error(msg);

`endif

// File: rtl/i2cebm_pkg.sv
package i2cebm_pkg;

    // Configuration register reset values.
    localparam logic [9:0]  HALF_PERIOD_RESET = 10'd5;
    localparam logic [6:0]  DEV_ADDR_RESET    = 7'd80;
    localparam logic [15:0] REC_TICKS_RESET   = 16'd1120;

    localparam int MAX_BURST_DEFAULT = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_DEV_ADDR    = 2'd1;
    localparam logic [1:0] CFG_REC_TICKS   = 2'd2;

    // Command codes carried in the input tuser.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Widths of the stream words.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // Bit positions inside the result tdata.
    localparam int OUT_SCL_BIT   = 0;
    localparam int OUT_SDA_BIT   = 1;
    localparam int OUT_BUSY_BIT  = 2;
    localparam int OUT_TAKEN_BIT = 3;
    localparam int OUT_RVAL_BIT  = 4;
    localparam int OUT_RBYTE_LSB = 5;
    localparam int OUT_NACK_BIT  = 13;

endpackage

// File: rtl/i2c_eeprom_burst_master_top.sv
// I2C EEPROM burst master. Every input word is one protocol tick: it carries a
// command in tuser (0 tick only, 1 begin a write burst, 2 begin a read burst;
// a begin is ignored while busy) and in tdata the start address, byte count,
// the next write byte and the sampled SDA level. For every input word exactly
// one result word comes back, holding the SCL and SDA levels to drive on this
// tick, busy, a write_data_taken strobe, a received byte with its valid flag,
// the sticky NACK flag, and tlast on the final byte of a read burst. A write
// burst sends START, device address with the write bit, the memory address and
// byte_count data bytes, then STOP and holds busy for write_recovery_ticks. A
// read burst adds a repeated START and the device address with the read bit,
// then receives byte_count bytes, acknowledging all but the last. Each tick
// is processed by the control logic in the cycle its word is accepted, and
// its result sits in the output register from the next cycle on, so a word
// can be accepted every cycle as long as the output register is empty or
// being drained. The configuration port takes a write every cycle and is
// meant to be used only while the block is idle.
module i2c_eeprom_burst_master_top
    import i2cebm_pkg::*;
#(
    parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] mem_address, [12:8] byte_count, [20:13] write_data, [21] sda_in,
    // [23:22] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] func
    input  logic [1:0]           s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] scl, [1] sda_out, [2] busy_res, [3] write_data_taken, [4] read_valid,
    // [12:5] read_byte, [13] nack_seen, [15:14] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // read_last
    output logic                 m_axis_tlast,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    // The count of bytes left must hold MAX_BURST itself.
    localparam int BL_W  = $clog2(MAX_BURST + 1);
    localparam int CNT_W = (BL_W > 5) ? BL_W : 5;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_TX_LO, PH_TX_HI, PH_SACK_LO, PH_SACK_HI,
        PH_RS_LO, PH_RS_HI, PH_RX_LO, PH_RX_HI, PH_MACK_LO, PH_MACK_HI,
        PH_SP_A, PH_SP_B, PH_SP_C, PH_REC
    } phase_t;

    // Which byte is on the wire: device address for write, memory address,
    // device address for read, or a data byte.
    typedef enum logic [1:0] {
        K_DEVW, K_MEM, K_DEVR, K_DATA
    } kind_t;

    // Configuration registers.
    logic [9:0]  half_period_reg;
    logic [6:0]  dev_addr_reg;
    logic [15:0] rec_ticks_reg;

    // Protocol state.
    phase_t          phase_reg, phase_next;
    kind_t           kind_reg, kind_next;
    logic [9:0]      tick_reg, tick_next;
    logic [3:0]      bit_idx_reg, bit_idx_next;
    logic [BL_W-1:0] bytes_left_reg, bytes_left_next;
    logic [7:0]      shifter_reg, shifter_next;
    logic [7:0]      addr_latch_reg, addr_latch_next;
    logic            read_mode_reg, read_mode_next;
    logic            nack_reg, nack_next;
    logic [15:0]     rec_cnt_reg, rec_cnt_next;

    // Result register.
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;

    // Unpacked input fields.
    logic [1:0] in_func;
    logic [7:0] in_mem;
    logic [4:0] in_count;
    logic [7:0] in_wdata;
    logic       in_sda;

    logic s_accept;

    assign in_func  = s_axis_tuser;
    assign in_mem   = s_axis_tdata[7:0];
    assign in_count = s_axis_tdata[12:8];
    assign in_wdata = s_axis_tdata[20:13];
    assign in_sda   = s_axis_tdata[21];

    // A new tick is taken whenever the result register is free or draining.
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    always_comb begin
        logic [CNT_W-1:0] cnt_ext;
        logic [9:0]       h;
        logic             busy;
        logic             scl;
        logic             sda;
        logic             taken;
        logic             rvalid;
        logic [7:0]       rbyte;
        logic             rlast;

        phase_next      = phase_reg;
        kind_next       = kind_reg;
        tick_next       = tick_reg;
        bit_idx_next    = bit_idx_reg;
        bytes_left_next = bytes_left_reg;
        shifter_next    = shifter_reg;
        addr_latch_next = addr_latch_reg;
        read_mode_next  = read_mode_reg;
        nack_next       = nack_reg;
        rec_cnt_next    = rec_cnt_reg;
        taken           = 1'b0;
        rvalid          = 1'b0;
        rbyte           = 8'd0;
        rlast           = 1'b0;
        scl             = 1'b1;
        sda             = 1'b1;
        h               = (half_period_reg == 10'd0) ? 10'd1 : half_period_reg;

        // A zero count means one byte, and the count saturates at MAX_BURST.
        cnt_ext = CNT_W'(in_count);
        if (cnt_ext == CNT_W'(0)) begin
            cnt_ext = CNT_W'(1);
        end
        if (cnt_ext > CNT_W'(MAX_BURST)) begin
            cnt_ext = CNT_W'(MAX_BURST);
        end

        // The begin tick is already the first tick of START.
        if (phase_reg == PH_IDLE && (in_func == FUNC_WRITE || in_func == FUNC_READ)) begin
            bytes_left_next = BL_W'(cnt_ext);
            addr_latch_next = in_mem;
            read_mode_next  = (in_func == FUNC_READ);
            nack_next       = 1'b0;
            kind_next       = K_DEVW;
            bit_idx_next    = 4'd0;
            tick_next       = 10'd0;
            phase_next      = PH_ST_A;
        end
        busy = (phase_next != PH_IDLE);

        // Line levels for this tick.
        unique case (phase_next)
            PH_ST_B, PH_SP_B: begin
                scl = 1'b1;
                sda = 1'b0;
            end
            PH_TX_LO: begin
                scl = 1'b0;
                sda = shifter_next[7];
            end
            PH_TX_HI: begin
                scl = 1'b1;
                sda = shifter_next[7];
            end
            PH_SACK_LO, PH_RS_LO, PH_RX_LO: begin
                scl = 1'b0;
                sda = 1'b1;
            end
            PH_MACK_LO: begin
                scl = 1'b0;
                sda = (bytes_left_next <= BL_W'(1));
            end
            PH_MACK_HI: begin
                scl = 1'b1;
                sda = (bytes_left_next <= BL_W'(1));
            end
            PH_SP_A: begin
                scl = 1'b0;
                sda = 1'b0;
            end
            default: begin
                scl = 1'b1;
                sda = 1'b1;
            end
        endcase

        if (phase_next == PH_REC) begin
            rec_cnt_next = rec_cnt_next + 16'd1;
            if (rec_cnt_next >= rec_ticks_reg) begin
                phase_next = PH_IDLE;
            end
        end else if (phase_next != PH_IDLE) begin
            if ({1'b0, tick_next} + 11'd1 < {1'b0, h}) begin
                tick_next = tick_next + 10'd1;
            end else begin
                tick_next = 10'd0;
                unique case (phase_next)
                    PH_ST_A: phase_next = PH_ST_B;
                    PH_ST_B: begin
                        shifter_next = {dev_addr_reg, kind_next == K_DEVR};
                        bit_idx_next = 4'd0;
                        phase_next   = PH_TX_LO;
                    end
                    PH_TX_LO: phase_next = PH_TX_HI;
                    PH_TX_HI: begin
                        shifter_next = {shifter_next[6:0], 1'b0};
                        bit_idx_next = bit_idx_next + 4'd1;
                        phase_next   = (bit_idx_next >= 4'd8) ? PH_SACK_LO : PH_TX_LO;
                    end
                    PH_SACK_LO: phase_next = PH_SACK_HI;
                    PH_SACK_HI: begin
                        // A missing acknowledge is only recorded.
                        nack_next = nack_next | in_sda;
                        unique case (kind_next)
                            K_DEVW: begin
                                shifter_next = addr_latch_next;
                                kind_next    = K_MEM;
                                bit_idx_next = 4'd0;
                                phase_next   = PH_TX_LO;
                            end
                            K_MEM: begin
                                if (read_mode_next) begin
                                    kind_next  = K_DEVR;
                                    phase_next = PH_RS_LO;
                                end else begin
                                    shifter_next = in_wdata;
                                    kind_next    = K_DATA;
                                    bit_idx_next = 4'd0;
                                    phase_next   = PH_TX_LO;
                                    taken        = 1'b1;
                                end
                            end
                            K_DEVR: begin
                                bit_idx_next = 4'd0;
                                shifter_next = 8'd0;
                                phase_next   = PH_RX_LO;
                            end
                            default: begin
                                if (bytes_left_next != BL_W'(0)) begin
                                    bytes_left_next = bytes_left_next - BL_W'(1);
                                end
                                if (bytes_left_next != BL_W'(0)) begin
                                    shifter_next = in_wdata;
                                    kind_next    = K_DATA;
                                    bit_idx_next = 4'd0;
                                    phase_next   = PH_TX_LO;
                                    taken        = 1'b1;
                                end else begin
                                    phase_next = PH_SP_A;
                                end
                            end
                        endcase
                    end
                    PH_RS_LO: phase_next = PH_RS_HI;
                    PH_RS_HI: phase_next = PH_ST_B;
                    PH_RX_LO: phase_next = PH_RX_HI;
                    PH_RX_HI: begin
                        shifter_next = {shifter_next[6:0], in_sda};
                        bit_idx_next = bit_idx_next + 4'd1;
                        if (bit_idx_next >= 4'd8) begin
                            rvalid     = 1'b1;
                            rbyte      = shifter_next;
                            rlast      = (bytes_left_next <= BL_W'(1));
                            phase_next = PH_MACK_LO;
                        end else begin
                            phase_next = PH_RX_LO;
                        end
                    end
                    PH_MACK_LO: phase_next = PH_MACK_HI;
                    PH_MACK_HI: begin
                        if (bytes_left_next != BL_W'(0)) begin
                            bytes_left_next = bytes_left_next - BL_W'(1);
                        end
                        if (bytes_left_next != BL_W'(0)) begin
                            bit_idx_next = 4'd0;
                            shifter_next = 8'd0;
                            phase_next   = PH_RX_LO;
                        end else begin
                            phase_next = PH_SP_A;
                        end
                    end
                    PH_SP_A: phase_next = PH_SP_B;
                    PH_SP_B: phase_next = PH_SP_C;
                    PH_SP_C: begin
                        if (!read_mode_next && rec_ticks_reg != 16'd0) begin
                            rec_cnt_next = 16'd0;
                            phase_next   = PH_REC;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end

        m_data_next = {2'b00, nack_next, rbyte, rvalid, taken, busy, sda, scl};
        m_last_next = rlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
            dev_addr_reg    <= DEV_ADDR_RESET;
            rec_ticks_reg   <= REC_TICKS_RESET;
            phase_reg       <= PH_IDLE;
            kind_reg        <= K_DEVW;
            tick_reg        <= 10'd0;
            bit_idx_reg     <= 4'd0;
            bytes_left_reg  <= BL_W'(0);
            shifter_reg     <= 8'd0;
            addr_latch_reg  <= 8'd0;
            read_mode_reg   <= 1'b0;
            nack_reg        <= 1'b0;
            rec_cnt_reg     <= 16'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_HALF_PERIOD: half_period_reg <= cfg_data[9:0];
                    CFG_DEV_ADDR:    dev_addr_reg    <= cfg_data[6:0];
                    CFG_REC_TICKS:   rec_ticks_reg   <= cfg_data;
                    default:         ;
                endcase
            end
            if (s_accept) begin
                phase_reg      <= phase_next;
                kind_reg       <= kind_next;
                tick_reg       <= tick_next;
                bit_idx_reg    <= bit_idx_next;
                bytes_left_reg <= bytes_left_next;
                shifter_reg    <= shifter_next;
                addr_latch_reg <= addr_latch_next;
                read_mode_reg  <= read_mode_next;
                nack_reg       <= nack_next;
                rec_cnt_reg    <= rec_cnt_next;
                m_valid_reg    <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
            m_last_reg <= m_last_next;
        end
    end

endmodule

// File: rtl/i2cebm_checker.sv
`include "i2c_eeprom_burst_master_top_defines.svh"

module i2cebm_checker
    import i2cebm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);

    // A stalled result word keeps its payload.
    `I2CEBM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result word changed while stalled")

    // When the block is not busy both lines are released.
    `I2CEBM_ASSERT(a_idle_lines, aclk, aresetn, (m_axis_tvalid && !m_axis_tdata[OUT_BUSY_BIT]) |-> (m_axis_tdata[OUT_SCL_BIT] && m_axis_tdata[OUT_SDA_BIT]), "lines not released while idle")

    // The last-byte mark only comes with a received byte.
    `I2CEBM_ASSERT(a_last_has_byte, aclk, aresetn, (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[OUT_RVAL_BIT], "read_last without read_valid")

    // Data strobes only occur inside a transaction, and never together.
    `I2CEBM_ASSERT(a_strobe_busy, aclk, aresetn, (m_axis_tvalid && (m_axis_tdata[OUT_TAKEN_BIT] || m_axis_tdata[OUT_RVAL_BIT])) |-> (m_axis_tdata[OUT_BUSY_BIT] && !(m_axis_tdata[OUT_TAKEN_BIT] && m_axis_tdata[OUT_RVAL_BIT])), "data strobe outside a transaction or both strobes set")

endmodule

bind i2c_eeprom_burst_master_top i2cebm_checker u_i2cebm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: dv/testbench.sv
module testbench;
    import i2cebm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Command code with no meaning of its own; the block treats it as a plain tick.
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int BURST_MAX = MAX_BURST_DEFAULT;
    // Cycles the receiver refuses results when a long hold-off is requested.
    localparam int LONG_HOLD_CYCLES = 300;
    // Mismatch lines printed before the report goes quiet (counting continues).
    localparam int REPORT_LIMIT = 40;
    // Words sent over the whole run, directed tests included; random traffic
    // fills up to this count.
    localparam int TOTAL_WORDS = 1450;

    // Predictor sequencer steps; each but idle and recovery lasts one half period.
    typedef enum logic [4:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_TX_LO, PH_TX_HI, PH_SACK_LO, PH_SACK_HI,
        PH_RS_LO, PH_RS_HI, PH_RX_LO, PH_RX_HI, PH_MACK_LO, PH_MACK_HI,
        PH_STOP_A, PH_STOP_B, PH_STOP_C, PH_RECOVER
    } line_phase_t;

    // Which byte is on the wire: device write, memory address, device read, data.
    typedef enum logic [1:0] {
        BYTE_DEV_WR, BYTE_MEM, BYTE_DEV_RD, BYTE_DATA
    } byte_kind_t;

    // How the modeled slave drives SDA whenever the master samples it.
    typedef enum logic [1:0] {
        SLAVE_ACK, SLAVE_HIGH, SLAVE_NOISY, SLAVE_SPARSE
    } slave_drive_t;

    // One result word, field by field.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       taken;
        logic       rvalid;
        logic [7:0] rbyte;
        logic       rlast;
        logic       nack;
    } tick_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [7:0] mem_address, [12:8] byte_count, [20:13] write_data, [21] sda_in, [23:22] zero
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // [1:0] func
    logic [1:0]           s_axis_tuser = FUNC_TICK;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [0] scl, [1] sda_out, [2] busy_res, [3] write_data_taken, [4] read_valid,
    // [12:5] read_byte, [13] nack_seen, [15:14] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // read_last
    logic                 m_axis_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = CFG_HALF_PERIOD;
    logic [15:0]          cfg_data = '0;

    i2c_eeprom_burst_master_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state. It mirrors the sequencer of the block and is only
    // advanced by predict_line_tick, once per accepted input word.
    // ------------------------------------------------------------------
    logic [9:0]   half_ticks_cfg = HALF_PERIOD_RESET;
    logic [6:0]   dev_addr_cfg   = DEV_ADDR_RESET;
    logic [15:0]  recovery_cfg   = REC_TICKS_RESET;

    line_phase_t  line_phase = PH_IDLE;
    int           step_ticks = 0;
    int           bits_done = 0;
    int           bytes_due = 0;
    logic [7:0]   shifter = '0;
    logic [7:0]   mem_latch = '0;
    logic         read_burst = 1'b0;
    logic         scl_drive = 1'b1;
    logic         sda_drive = 1'b1;
    logic         nack_sticky = 1'b0;
    logic [15:0]  recovery_ticks = '0;
    byte_kind_t   wire_byte = BYTE_DEV_WR;

    // Expected result words, oldest first.
    tick_result_t expected_ticks[$];

    // Bookkeeping for the summary and the mismatch report.
    int words_sent = 0;
    int words_checked = 0;
    int mismatch_count = 0;
    int bursts_begun = 0;
    int bytes_written = 0;
    int bytes_read = 0;
    int nack_bytes = 0;
    int settings_applied = 0;

    // Sender burst/gap state and receiver hold-off requests.
    int burst_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int pattern_left = 0;
    logic [15:0] ready_pattern = 16'hFFFF;

    // Puts a byte on the shifter and starts sending it from its MSB.
    function automatic void load_tx_byte(input logic [7:0] value, input byte_kind_t kind);
        shifter = value;
        wire_byte = kind;
        bits_done = 0;
        line_phase = PH_TX_LO;
    endfunction

    // Advances the predicted sequencer by one tick and returns the result word
    // that the block must produce for it.
    function automatic tick_result_t predict_line_tick(input logic [1:0] fn,
                                                      input logic [7:0] mem,
                                                      input logic [4:0] cnt,
                                                      input logic [7:0] wdata,
                                                      input logic sda_in);
        tick_result_t r;
        int n;
        int h;
        r = '0;
        if (line_phase == PH_IDLE && (fn == FUNC_WRITE || fn == FUNC_READ)) begin
            n = cnt;
            if (n == 0) n = 1;
            if (n > BURST_MAX) n = BURST_MAX;
            bytes_due = n;
            mem_latch = mem;
            read_burst = (fn == FUNC_READ);
            nack_sticky = 1'b0;
            wire_byte = BYTE_DEV_WR;
            bits_done = 0;
            step_ticks = 0;
            line_phase = PH_START_A;
        end
        r.busy = (line_phase != PH_IDLE);

        // Line levels belong to the step the tick is in, before it advances.
        case (line_phase)
            PH_START_B, PH_STOP_B: begin
                scl_drive = 1'b1; sda_drive = 1'b0;
            end
            PH_TX_LO: begin
                scl_drive = 1'b0; sda_drive = shifter[7];
            end
            PH_TX_HI: begin
                scl_drive = 1'b1; sda_drive = shifter[7];
            end
            PH_SACK_LO, PH_RS_LO, PH_RX_LO: begin
                scl_drive = 1'b0; sda_drive = 1'b1;
            end
            PH_MACK_LO: begin
                scl_drive = 1'b0; sda_drive = (bytes_due <= 1);
            end
            PH_MACK_HI: begin
                scl_drive = 1'b1; sda_drive = (bytes_due <= 1);
            end
            PH_STOP_A: begin
                scl_drive = 1'b0; sda_drive = 1'b0;
            end
            default: begin
                scl_drive = 1'b1; sda_drive = 1'b1;
            end
        endcase

        if (line_phase == PH_RECOVER) begin
            recovery_ticks = recovery_ticks + 16'd1;
            if (recovery_ticks >= recovery_cfg) line_phase = PH_IDLE;
        end else if (line_phase != PH_IDLE) begin
            h = (half_ticks_cfg == 0) ? 1 : int'(half_ticks_cfg);
            if (step_ticks + 1 < h) begin
                step_ticks = step_ticks + 1;
            end else begin
                step_ticks = 0;
                case (line_phase)
                    PH_START_A: line_phase = PH_START_B;
                    PH_START_B: load_tx_byte({dev_addr_cfg, wire_byte == BYTE_DEV_RD},
                                             wire_byte);
                    PH_TX_LO:   line_phase = PH_TX_HI;
                    PH_TX_HI: begin
                        shifter = {shifter[6:0], 1'b0};
                        bits_done = bits_done + 1;
                        line_phase = (bits_done >= 8) ? PH_SACK_LO : PH_TX_LO;
                    end
                    PH_SACK_LO: line_phase = PH_SACK_HI;
                    PH_SACK_HI: begin
                        nack_sticky = nack_sticky | sda_in;
                        case (wire_byte)
                            BYTE_DEV_WR: load_tx_byte(mem_latch, BYTE_MEM);
                            BYTE_MEM: begin
                                if (read_burst) begin
                                    wire_byte = BYTE_DEV_RD;
                                    line_phase = PH_RS_LO;
                                end else begin
                                    load_tx_byte(wdata, BYTE_DATA);
                                    r.taken = 1'b1;
                                end
                            end
                            BYTE_DEV_RD: begin
                                bits_done = 0;
                                shifter = '0;
                                line_phase = PH_RX_LO;
                            end
                            default: begin
                                if (bytes_due > 0) bytes_due = bytes_due - 1;
                                if (bytes_due > 0) begin
                                    load_tx_byte(wdata, BYTE_DATA);
                                    r.taken = 1'b1;
                                end else begin
                                    line_phase = PH_STOP_A;
                                end
                            end
                        endcase
                    end
                    PH_RS_LO: line_phase = PH_RS_HI;
                    PH_RS_HI: line_phase = PH_START_B;
                    PH_RX_LO: line_phase = PH_RX_HI;
                    PH_RX_HI: begin
                        shifter = {shifter[6:0], sda_in};
                        bits_done = bits_done + 1;
                        if (bits_done >= 8) begin
                            r.rvalid = 1'b1;
                            r.rbyte = shifter;
                            r.rlast = (bytes_due <= 1);
                            line_phase = PH_MACK_LO;
                        end else begin
                            line_phase = PH_RX_LO;
                        end
                    end
                    PH_MACK_LO: line_phase = PH_MACK_HI;
                    PH_MACK_HI: begin
                        if (bytes_due > 0) bytes_due = bytes_due - 1;
                        if (bytes_due > 0) begin
                            bits_done = 0;
                            shifter = '0;
                            line_phase = PH_RX_LO;
                        end else begin
                            line_phase = PH_STOP_A;
                        end
                    end
                    PH_STOP_A: line_phase = PH_STOP_B;
                    PH_STOP_B: line_phase = PH_STOP_C;
                    PH_STOP_C: begin
                        if (!read_burst && recovery_cfg > 0) begin
                            recovery_ticks = '0;
                            line_phase = PH_RECOVER;
                        end else begin
                            line_phase = PH_IDLE;
                        end
                    end
                    default: line_phase = PH_IDLE;
                endcase
            end
        end

        r.scl = scl_drive;
        r.sda = sda_drive;
        r.nack = nack_sticky;
        return r;
    endfunction

    // Level the modeled slave puts on SDA for one tick.
    function automatic logic slave_level(input slave_drive_t drive);
        case (drive)
            SLAVE_ACK:    return 1'b0;
            SLAVE_HIGH:   return 1'b1;
            SLAVE_SPARSE: return ($urandom_range(0, 7) == 0);
            default:      return logic'($urandom_range(0, 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender. Words go out in bursts of random length; between bursts the
    // valid is dropped for a random gap, sometimes none at all. The
    // expectation is computed at the edge where the word is taken.
    // ------------------------------------------------------------------
    task automatic send_tick(input logic [1:0] fn, input logic [7:0] mem,
                             input logic [4:0] cnt, input logic [7:0] wdata,
                             input logic sda_in);
        tick_result_t want;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left = burst_left - 1;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {2'b00, sda_in, wdata, cnt, mem};
        do @(posedge aclk); while (!s_axis_tready);
        if (line_phase == PH_IDLE && (fn == FUNC_WRITE || fn == FUNC_READ))
            bursts_begun = bursts_begun + 1;
        want = predict_line_tick(fn, mem, cnt, wdata, sda_in);
        expected_ticks.push_back(want);
        words_sent = words_sent + 1;
        if (want.taken) bytes_written = bytes_written + 1;
        if (want.rvalid) bytes_read = bytes_read + 1;
    endtask

    // Keeps ticking until the predicted sequencer reaches the given step. While
    // busy, the command field is random so that begin requests arrive and must
    // be ignored.
    task automatic tick_until(input line_phase_t target, input slave_drive_t drive);
        while (line_phase != target)
            send_tick(2'($urandom_range(0, 3)), 8'($urandom), 5'($urandom), 8'($urandom),
                      slave_level(drive));
    endtask

    // Sends up to count such ticks, stopping early once the sequencer is idle.
    task automatic busy_ticks(input int count, input slave_drive_t drive);
        for (int i = 0; i < count; i++) begin
            if (line_phase == PH_IDLE) break;
            send_tick(2'($urandom_range(0, 3)), 8'($urandom), 5'($urandom), 8'($urandom),
                      slave_level(drive));
        end
    endtask

    // Starts a burst and keeps ticking until the predicted sequencer is idle
    // again.
    task automatic run_burst(input logic [1:0] fn, input logic [7:0] mem,
                             input logic [4:0] cnt, input slave_drive_t drive);
        send_tick(fn, mem, cnt, 8'($urandom), slave_level(drive));
        tick_until(PH_IDLE, drive);
    endtask

    // Lets every result drain and then writes all three registers back to back.
    // The sequencer may be in the middle of a burst; the new values apply from
    // the next word on.
    task automatic write_settings(input logic [9:0] half_ticks, input logic [6:0] dev_addr,
                                  input logic [15:0] recovery);
        logic [1:0]  reg_index [3];
        logic [15:0] reg_value [3];
        reg_index[0] = CFG_HALF_PERIOD;
        reg_index[1] = CFG_DEV_ADDR;
        reg_index[2] = CFG_REC_TICKS;
        reg_value[0] = {6'd0, half_ticks};
        reg_value[1] = {9'd0, dev_addr};
        reg_value[2] = recovery;
        s_axis_tvalid <= 1'b0;
        while (expected_ticks.size() > 0) @(posedge aclk);
        // Every word yields one result, so a short pause covers the pipeline.
        repeat (3) @(posedge aclk);
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index[i];
            cfg_data  <= reg_value[i];
            do @(posedge aclk); while (!cfg_ready);
            case (reg_index[i])
                CFG_HALF_PERIOD: half_ticks_cfg = reg_value[i][9:0];
                CFG_DEV_ADDR:    dev_addr_cfg = reg_value[i][6:0];
                default:         recovery_cfg = reg_value[i];
            endcase
        end
        cfg_valid <= 1'b0;
        settings_applied = settings_applied + 1;
    endtask

    // Brings the block to rest (sequencer idle, every result drained) and then
    // writes all three registers.
    task automatic apply_settings(input logic [9:0] half_ticks, input logic [6:0] dev_addr,
                                  input logic [15:0] recovery);
        while (line_phase != PH_IDLE)
            send_tick(FUNC_TICK, 8'($urandom), 5'($urandom), 8'($urandom),
                      logic'($urandom_range(0, 1)));
        write_settings(half_ticks, dev_addr, recovery);
    endtask

    // ------------------------------------------------------------------
    // Receiver. It follows a ready pattern that is redrawn every so often:
    // always ready, random, mostly ready, or a single stall per pass through
    // the sixteen-bit pattern. A long hold-off request overrides it for a while.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: ready_pattern = 16'hFFFF;
                    1: ready_pattern = 16'($urandom);
                    2: ready_pattern = 16'($urandom) | 16'($urandom);
                    default: ready_pattern = ~(16'h1 << $urandom_range(0, 15));
                endcase
            end
            pattern_left = pattern_left - 1;
            m_axis_tready <= ready_pattern[pattern_left % 16];
        end
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatch_count < REPORT_LIMIT)
            $display("mismatch at result word %0d: %s is %0h, expected %0h",
                     words_checked, field, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    // Result checker: every taken result word is held against the oldest
    // expectation, one field at a time.
    always @(posedge aclk) begin : check_results
        tick_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_ticks.size() == 0) begin
                report_mismatch("unexpected result word, tdata", int'(m_axis_tdata), 0);
            end else begin
                want = expected_ticks.pop_front();
                if (m_axis_tdata[OUT_SCL_BIT] !== want.scl)
                    report_mismatch("scl", int'(m_axis_tdata[OUT_SCL_BIT]), int'(want.scl));
                if (m_axis_tdata[OUT_SDA_BIT] !== want.sda)
                    report_mismatch("sda_out", int'(m_axis_tdata[OUT_SDA_BIT]), int'(want.sda));
                if (m_axis_tdata[OUT_BUSY_BIT] !== want.busy)
                    report_mismatch("busy", int'(m_axis_tdata[OUT_BUSY_BIT]), int'(want.busy));
                if (m_axis_tdata[OUT_TAKEN_BIT] !== want.taken)
                    report_mismatch("write_data_taken", int'(m_axis_tdata[OUT_TAKEN_BIT]),
                                    int'(want.taken));
                if (m_axis_tdata[OUT_RVAL_BIT] !== want.rvalid)
                    report_mismatch("read_valid", int'(m_axis_tdata[OUT_RVAL_BIT]),
                                    int'(want.rvalid));
                if (m_axis_tdata[OUT_RBYTE_LSB +: 8] !== want.rbyte)
                    report_mismatch("read_byte", int'(m_axis_tdata[OUT_RBYTE_LSB +: 8]),
                                    int'(want.rbyte));
                if (m_axis_tdata[OUT_NACK_BIT] !== want.nack)
                    report_mismatch("nack_seen", int'(m_axis_tdata[OUT_NACK_BIT]),
                                    int'(want.nack));
                if (m_axis_tdata[M_TDATA_W-1:OUT_NACK_BIT+1] !== '0)
                    report_mismatch("padding", int'(m_axis_tdata[M_TDATA_W-1:OUT_NACK_BIT+1]), 0);
                if (m_axis_tlast !== want.rlast)
                    report_mismatch("read_last", int'(m_axis_tlast), int'(want.rlast));
            end
            words_checked = words_checked + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain ticks and the spare command code must leave both lines released.
    task automatic test_idle_lines();
        send_tick(FUNC_TICK, 8'hFF, 5'h1F, 8'hFF, 1'b1);
        send_tick(FUNC_TICK, 8'h00, 5'h00, 8'h00, 1'b0);
        send_tick(FUNC_SPARE, 8'hFF, 5'h10, 8'hAA, 1'b1);
        send_tick(FUNC_SPARE, 8'h00, 5'h01, 8'h55, 1'b0);
    endtask

    // Write bursts: the device address byte at the reset half period and address,
    // part of the reset recovery wait, then a zero byte count and a longer burst.
    task automatic test_write_bursts();
        send_tick(FUNC_WRITE, 8'h00, 5'd1, 8'($urandom), 1'b0);
        busy_ticks(95, SLAVE_ACK);
        write_settings(10'd1, DEV_ADDR_RESET, REC_TICKS_RESET);
        tick_until(PH_RECOVER, SLAVE_ACK);
        busy_ticks(40, SLAVE_ACK);
        // A recovery bound below the running count ends the wait on the next tick.
        write_settings(10'd1, DEV_ADDR_RESET, 16'd1);
        tick_until(PH_IDLE, SLAVE_ACK);
        apply_settings(10'd1, 7'd0, 16'd0);
        run_burst(FUNC_WRITE, 8'hFF, 5'd0, SLAVE_ACK);
        apply_settings(10'd1, 7'h55, 16'd9);
        run_burst(FUNC_WRITE, 8'hA5, 5'd8, SLAVE_SPARSE);
    endtask

    // Read bursts: a byte count that saturates to the longest burst.
    task automatic test_read_bursts();
        apply_settings(10'd1, 7'd80, 16'd0);
        run_burst(FUNC_READ, 8'h3C, 5'd31, SLAVE_NOISY);
    endtask

    // A slave that never acknowledges: the sticky flag sets, nothing aborts.
    task automatic test_nack_paths();
        run_burst(FUNC_WRITE, 8'h81, 5'd1, SLAVE_HIGH);
        run_burst(FUNC_READ, 8'h7E, 5'd1, SLAVE_HIGH);
    endtask

    // Register extremes: the longest half period cut short by a zero half
    // period in the middle of a step, then the longest recovery cut short in the
    // middle of the wait, and a read at zero half period.
    task automatic test_register_extremes();
        apply_settings(10'd1023, 7'd127, 16'hFFFF);
        send_tick(FUNC_WRITE, 8'h12, 5'd1, 8'($urandom), 1'b0);
        busy_ticks(40, SLAVE_ACK);
        write_settings(10'd0, 7'd127, 16'hFFFF);
        tick_until(PH_RECOVER, SLAVE_ACK);
        busy_ticks(30, SLAVE_ACK);
        write_settings(10'd0, 7'd127, 16'd5);
        tick_until(PH_IDLE, SLAVE_ACK);
        run_burst(FUNC_READ, 8'h34, 5'd1, SLAVE_NOISY);
    endtask

    // The receiver stops taking results for a long stretch while the sender
    // keeps offering words, so the output register fills and input stalls.
    task automatic test_output_backpressure();
        apply_settings(10'd1, 7'd80, 16'd3);
        hold_requests = hold_requests + 1;
        run_burst(FUNC_READ, 8'h40, 5'd2, SLAVE_NOISY);
        run_burst(FUNC_WRITE, 8'hC3, 5'd2, SLAVE_SPARSE);
    endtask

    // Complete bursts with random content, mixed with stray ticks, until the run has sent
    // its share of words; settings are redrawn first and after each 300+ more.
    task automatic test_random_traffic();
        int cfg_mark;
        int pick;
        logic [4:0] cnt;
        logic [9:0] half_ticks;
        cfg_mark = words_sent - 1000;
        while (words_sent < TOTAL_WORDS) begin
            if (words_sent - cfg_mark > 300) begin
                cfg_mark = words_sent;
                case ($urandom_range(0, 5))
                    0:       half_ticks = 10'd0;
                    4:       half_ticks = 10'd2;
                    default: half_ticks = 10'd1;
                endcase
                apply_settings(half_ticks, 7'($urandom),
                               ($urandom_range(0, 1) == 0) ? 16'd0 :
                               16'($urandom_range(1, 30)));
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) cnt = 5'($urandom_range(1, 3));
            else if (pick < 8) cnt = 5'($urandom_range(4, 16));
            else if (pick == 8) cnt = 5'd0;
            else cnt = 5'($urandom_range(17, 31));
            if ($urandom_range(0, 99) < 85) begin
                run_burst(($urandom_range(0, 1) == 0) ? FUNC_WRITE : FUNC_READ,
                          8'($urandom), cnt, slave_drive_t'($urandom_range(0, 3)));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_tick(($urandom_range(0, 1) == 0) ? FUNC_TICK : FUNC_SPARE,
                              8'($urandom), 5'($urandom), 8'($urandom),
                              logic'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_lines();
        test_write_bursts();
        test_read_bursts();
        test_nack_paths();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (expected_ticks.size() > 0) @(posedge aclk);
        // Give a stray extra result the chance to show up.
        repeat (8) @(posedge aclk);

        $display("Ran %0d tick words with %0d settings: %0d bursts begun, %0d bytes written,",
                 words_sent, settings_applied, bursts_begun, bytes_written);
        $display("%0d bytes read, %0d result words checked, %0d mismatches.",
                 bytes_read, words_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: many times the slowest correct run, even with heavy result
    // stalls, the long hold-off and every sender gap at its longest.
    initial begin
        #400_000;
        $display("timeout with %0d result words still expected", expected_ticks.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
